// ===== rtl/uwmrp_pkg.sv =====
// Package for the write-memory-by-address request parser.
// Holds status codes, field widths and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package uwmrp_pkg;

    localparam int MAX_RECORD_LEN_DEF = 4096;

    localparam int BYTE_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int ACCUM_W  = 32;
    localparam int LEN_W    = 3;
    localparam int OFFSET_W = 4;
    localparam int HEADER_W = 5;
    localparam int TOTAL_W  = ACCUM_W + 1;

    localparam logic [NIBBLE_W-1:0] MAX_FIELD_BYTES = 4'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OUT_RANGE = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

    typedef struct packed {
        logic [1:0]          status;
        logic [ACCUM_W-1:0]  mem_address;
        logic [ACCUM_W-1:0]  mem_size;
        logic [LEN_W-1:0]    address_bytes;
        logic [LEN_W-1:0]    size_bytes;
        logic [OFFSET_W-1:0] data_offset;
    } result_t;

endpackage

// ===== rtl/uwmrp_req_if.sv =====
// Request byte channel: one record byte and its last-byte mark per transaction.
// Depends on uwmrp_pkg.
`timescale 1ns / 1ps

interface uwmrp_req_if;
    logic                         valid;
    logic                         ready;
    logic [uwmrp_pkg::BYTE_W-1:0] rx_byte;
    logic                         last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// ===== rtl/uwmrp_rsp_if.sv =====
// Result channel: one parse result per transaction.
// Depends on uwmrp_pkg.
`timescale 1ns / 1ps

interface uwmrp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [uwmrp_pkg::ACCUM_W-1:0]  mem_address;
    logic [uwmrp_pkg::ACCUM_W-1:0]  mem_size;
    logic [uwmrp_pkg::LEN_W-1:0]    address_bytes;
    logic [uwmrp_pkg::LEN_W-1:0]    size_bytes;
    logic [uwmrp_pkg::OFFSET_W-1:0] data_offset;

    modport source (output valid, output status, output mem_address, output mem_size,
                    output address_bytes, output size_bytes, output data_offset,
                    input ready);
    modport sink   (input valid, input status, input mem_address, input mem_size,
                    input address_bytes, input size_bytes, input data_offset,
                    output ready);
endinterface

// ===== rtl/uwmrp_accum.sv =====
// Record state and per-byte update: format nibbles, address/size accumulators,
// saturating byte count, and the result decision on the last byte.
// Depends on uwmrp_pkg.
`timescale 1ns / 1ps

module uwmrp_accum #(
    parameter int MAX_RECORD_LEN = uwmrp_pkg::MAX_RECORD_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [uwmrp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                         last_byte,
    output logic                         result_valid,
    output uwmrp_pkg::result_t           result
);

    localparam int CNT_W = $clog2(MAX_RECORD_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORD_LEN);

    logic [CNT_W-1:0]                    byte_count_reg, byte_count_next;
    logic [uwmrp_pkg::NIBBLE_W-1:0]      addr_nibble_reg, addr_nibble_next;
    logic [uwmrp_pkg::NIBBLE_W-1:0]      size_nibble_reg, size_nibble_next;
    logic [uwmrp_pkg::ACCUM_W-1:0]       addr_accum_reg, addr_accum_next;
    logic [uwmrp_pkg::ACCUM_W-1:0]       size_accum_reg, size_accum_next;

    logic                                first;
    logic                                nib_ok;
    logic [uwmrp_pkg::HEADER_W-1:0]      field_sum;
    logic [uwmrp_pkg::HEADER_W-1:0]      header;
    logic [CNT_W-1:0]                    count_upd;
    logic [uwmrp_pkg::TOTAL_W-1:0]       total;
    logic [1:0]                          status;

    always_comb
    begin
        first            = (byte_count_reg == '0);
        addr_nibble_next = first ? rx_byte[3:0] : addr_nibble_reg;
        size_nibble_next = first ? rx_byte[7:4] : size_nibble_reg;
        nib_ok = (addr_nibble_next <= uwmrp_pkg::MAX_FIELD_BYTES) &&
                 (size_nibble_next <= uwmrp_pkg::MAX_FIELD_BYTES);
        field_sum = {1'b0, addr_nibble_next} + {1'b0, size_nibble_next};
        header    = field_sum + uwmrp_pkg::HEADER_W'(1);

        addr_accum_next = addr_accum_reg;
        size_accum_next = size_accum_reg;
        if (!first && nib_ok)
        begin
            if (byte_count_reg <= CNT_W'(addr_nibble_next))
                addr_accum_next = {addr_accum_reg[uwmrp_pkg::ACCUM_W-9:0], rx_byte};
            else if (byte_count_reg <= CNT_W'(field_sum))
                size_accum_next = {size_accum_reg[uwmrp_pkg::ACCUM_W-9:0], rx_byte};
        end

        // saturate at the record bound
        count_upd = (byte_count_reg < CNT_MAX) ? byte_count_reg + CNT_W'(1) : byte_count_reg;

        total = {1'b0, size_accum_next} + uwmrp_pkg::TOTAL_W'(header);

        if (!nib_ok)
            status = uwmrp_pkg::STATUS_OUT_RANGE;
        else if (count_upd >= CNT_MAX)
            status = uwmrp_pkg::STATUS_BAD_LEN;
        else if (count_upd < CNT_W'(header))
            status = uwmrp_pkg::STATUS_BAD_LEN;
        else if (uwmrp_pkg::TOTAL_W'(count_upd) != total)
            status = uwmrp_pkg::STATUS_BAD_LEN;
        else
            status = uwmrp_pkg::STATUS_OK;

        result = '0;
        result.status = status;
        if (status == uwmrp_pkg::STATUS_OK)
        begin
            result.mem_address   = addr_accum_next;
            result.mem_size      = size_accum_next;
            result.address_bytes = addr_nibble_next[uwmrp_pkg::LEN_W-1:0];
            result.size_bytes    = size_nibble_next[uwmrp_pkg::LEN_W-1:0];
            result.data_offset   = header[uwmrp_pkg::OFFSET_W-1:0];
        end

        result_valid    = accept && last_byte;
        byte_count_next = last_byte ? '0 : count_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            addr_nibble_reg <= '0;
            size_nibble_reg <= '0;
            addr_accum_reg  <= '0;
            size_accum_reg  <= '0;
        end
        else if (accept)
        begin
            byte_count_reg <= byte_count_next;
            // clear everything at record end
            if (last_byte)
            begin
                addr_nibble_reg <= '0;
                size_nibble_reg <= '0;
                addr_accum_reg  <= '0;
                size_accum_reg  <= '0;
            end
            else
            begin
                addr_nibble_reg <= addr_nibble_next;
                size_nibble_reg <= size_nibble_next;
                addr_accum_reg  <= addr_accum_next;
                size_accum_reg  <= size_accum_next;
            end
        end
    end

endmodule

// ===== rtl/uds_write_memory_request_parser.sv =====
// Top level of the write-memory-by-address request parser.
// Depends on uwmrp_pkg, uwmrp_req_if, uwmrp_rsp_if and uwmrp_accum.
//
//   Port  Direction  Transaction carries
//   req   in         rx_byte, last_byte (one record byte)
//   rsp   out        status, mem_address, mem_size, address_bytes, size_bytes, data_offset
//
// One byte is taken per cycle; the result of a record's last byte is registered
// and appears on rsp the cycle after that byte is taken.
// Reset (rst_n low, asynchronous) clears the record state and the result valid flag.
// req is stalled only while a result is held in the output register and rsp is
// not ready in the same cycle.
`timescale 1ns / 1ps

module uds_write_memory_request_parser #(
    parameter int MAX_RECORD_LEN = uwmrp_pkg::MAX_RECORD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    uwmrp_req_if.sink   req,
    uwmrp_rsp_if.source rsp
);

    logic               accept;
    logic               result_valid;
    uwmrp_pkg::result_t result;
    logic               out_valid_reg;
    uwmrp_pkg::result_t out_data_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    uwmrp_accum #(
        .MAX_RECORD_LEN (MAX_RECORD_LEN)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (req.rx_byte),
        .last_byte    (req.last_byte),
        .result_valid (result_valid),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_valid)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (result_valid)
            out_data_reg <= result;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_data_reg.status;
    assign rsp.mem_address   = out_data_reg.mem_address;
    assign rsp.mem_size      = out_data_reg.mem_size;
    assign rsp.address_bytes = out_data_reg.address_bytes;
    assign rsp.size_bytes    = out_data_reg.size_bytes;
    assign rsp.data_offset   = out_data_reg.data_offset;

endmodule

// ===== tb/sv/tb_uds_write_memory_request_parser.sv =====
// Self-checking bench for the write-memory-by-address request parser.
// Depends on uwmrp_pkg, uwmrp_req_if, uwmrp_rsp_if and the parser top level.
// Drives record bytes with random gaps, predicts each result and checks it.
`timescale 1ns / 1ps

module tb_uds_write_memory_request_parser;

    localparam int REC_MAX      = 4096;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        logic [uwmrp_pkg::BYTE_W-1:0] data;
        logic                         last;
    } rec_byte_t;

    logic clk;
    logic rst_n;

    uwmrp_req_if req_ch ();
    uwmrp_rsp_if rsp_ch ();

    uds_write_memory_request_parser #(
        .MAX_RECORD_LEN(REC_MAX)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rec_byte_t          tx_bytes[$];
    uwmrp_pkg::result_t pending_results[$];
    rec_byte_t          drv_byte;
    uwmrp_pkg::result_t predicted;
    uwmrp_pkg::result_t observed;
    int                 n_pushed;
    int                 errors = 0;
    int                 cycles;
    int                 src_gap;
    int                 sink_hold;
    bit                 quiet;
    bit                 long_hold_req;
    bit                 long_hold_done;
    bit                 req_taken;

    // parser state mirror
    int unsigned                    rec_cnt;
    logic [uwmrp_pkg::NIBBLE_W-1:0] fmt_addr_n;
    logic [uwmrp_pkg::NIBBLE_W-1:0] fmt_size_n;
    logic [uwmrp_pkg::ACCUM_W-1:0]  addr_acc;
    logic [uwmrp_pkg::ACCUM_W-1:0]  size_acc;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_parse_state();
        rec_cnt    = 0;
        fmt_addr_n = '0;
        fmt_size_n = '0;
        addr_acc   = '0;
        size_acc   = '0;
    endfunction

    // Advance the parser mirror by one byte; return 1 when a result is due.
    function automatic bit parse_record_byte(input logic [uwmrp_pkg::BYTE_W-1:0] b,
                                             input logic lst,
                                             output uwmrp_pkg::result_t res);
        bit                  nib_ok;
        int unsigned         header;
        longint unsigned     total;
        logic [1:0]          st;
        res = '0;
        nib_ok = (fmt_addr_n <= uwmrp_pkg::MAX_FIELD_BYTES) &&
                 (fmt_size_n <= uwmrp_pkg::MAX_FIELD_BYTES);
        if (rec_cnt == 0)
        begin
            fmt_addr_n = b[3:0];
            fmt_size_n = b[7:4];
        end
        else if (nib_ok)
        begin
            if (rec_cnt <= fmt_addr_n)
                addr_acc = {addr_acc[uwmrp_pkg::ACCUM_W-uwmrp_pkg::BYTE_W-1:0], b};
            else if (rec_cnt <= int'(fmt_addr_n) + int'(fmt_size_n))
                size_acc = {size_acc[uwmrp_pkg::ACCUM_W-uwmrp_pkg::BYTE_W-1:0], b};
        end
        if (rec_cnt < REC_MAX)
            rec_cnt++;
        if (!lst)
            return 1'b0;

        nib_ok = (fmt_addr_n <= uwmrp_pkg::MAX_FIELD_BYTES) &&
                 (fmt_size_n <= uwmrp_pkg::MAX_FIELD_BYTES);
        header = 1 + int'(fmt_addr_n) + int'(fmt_size_n);
        total  = longint'(header) + longint'(size_acc);
        if (!nib_ok)
            st = uwmrp_pkg::STATUS_OUT_RANGE;
        else if (rec_cnt >= REC_MAX)
            st = uwmrp_pkg::STATUS_BAD_LEN;
        else if (rec_cnt < header)
            st = uwmrp_pkg::STATUS_BAD_LEN;
        else if (longint'(rec_cnt) != total)
            st = uwmrp_pkg::STATUS_BAD_LEN;
        else
            st = uwmrp_pkg::STATUS_OK;

        res.status = st;
        if (st == uwmrp_pkg::STATUS_OK)
        begin
            res.mem_address   = addr_acc;
            res.mem_size      = size_acc;
            res.address_bytes = fmt_addr_n[uwmrp_pkg::LEN_W-1:0];
            res.size_bytes    = fmt_size_n[uwmrp_pkg::LEN_W-1:0];
            res.data_offset   = header[uwmrp_pkg::OFFSET_W-1:0];
        end
        clear_parse_state();
        return 1'b1;
    endfunction

    function automatic void compare_field(input string fname, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
        end
    endfunction

    // Build one record: format byte, address and size big-endian, then payload.
    // A nonzero keep shorter than the record cuts the record to that many bytes.
    task automatic add_record(input logic [7:0] fmt, input logic [31:0] addr,
                              input logic [31:0] size, input int pay_len, input int keep);
        logic [7:0] bytes_q[$];
        rec_byte_t  rb;
        int         an;
        int         sn;
        int         n;
        an = fmt[3:0];
        sn = fmt[7:4];
        bytes_q.push_back(fmt);
        for (int i = an - 1; i >= 0; i--)
        begin
            if (i < 4)
                bytes_q.push_back(addr[8*i +: 8]);
            else
                bytes_q.push_back(8'($urandom));
        end
        for (int i = sn - 1; i >= 0; i--)
        begin
            if (i < 4)
                bytes_q.push_back(size[8*i +: 8]);
            else
                bytes_q.push_back(8'($urandom));
        end
        for (int i = 0; i < pay_len; i++)
            bytes_q.push_back(8'($urandom));
        n = (keep > 0 && keep < bytes_q.size()) ? keep : bytes_q.size();
        for (int k = 0; k < n; k++)
        begin
            rb.data = bytes_q[k];
            rb.last = (k == n - 1);
            tx_bytes.push_back(rb);
        end
        n_pushed += n;
    endtask

    task automatic add_random_record();
        logic [7:0]  fmt;
        logic [31:0] size;
        int          sel;
        int          an;
        int          sn;
        int          header;
        sel = $urandom_range(0, 99);
        an  = $urandom_range(0, 4);
        sn  = $urandom_range(0, 4);
        fmt = {4'(sn), 4'(an)};
        header = 1 + an + sn;
        size = (sn == 0) ? 32'd0 :
               ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 40)) :
                                            32'($urandom_range(0, 12));
        if (sel < 70)
            add_record(fmt, $urandom, size, size, 0);
        else if (sel < 78)
            add_record(fmt, $urandom, size, size + $urandom_range(1, 3), 0);
        else if (sel < 84 && size > 0)
            add_record(fmt, $urandom, size, size - 1, 0);
        else if (sel < 90 && header > 1)
            add_record(fmt, $urandom, size, size, $urandom_range(1, header - 1));
        else
            add_record(8'($urandom), $urandom, $urandom, $urandom_range(0, 6),
                       $urandom_range(1, 12));
    endtask

    task automatic wait_all_done();
        while (tx_bytes.size() != 0 || req_ch.valid || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // source side: hold the transaction until taken, then advance
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.rx_byte   <= '0;
            req_ch.last_byte <= 1'b0;
            src_gap          <= 0;
        end
        else if (!req_ch.valid || req_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap      <= src_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (tx_bytes.size() == 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                src_gap      <= $urandom_range(0, 11);
                req_ch.valid <= 1'b0;
            end
            else
            begin
                drv_byte          = tx_bytes.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.rx_byte   <= drv_byte.data;
                req_ch.last_byte <= drv_byte.last;
            end
        end
    end

    // sink side: random stall bursts plus one long hold on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready   <= 1'b0;
            sink_hold      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold    <= sink_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            sink_hold      <= LONG_HOLD - 1;
            rsp_ch.ready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 15) == 0)
        begin
            sink_hold    <= $urandom_range(0, 11);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            cycles    <= 0;
            clear_parse_state();
        end
        else
        begin
            cycles    <= cycles + 1;
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                if (parse_record_byte(req_ch.rx_byte, req_ch.last_byte, predicted))
                    pending_results.push_back(predicted);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                observed.status        = rsp_ch.status;
                observed.mem_address   = rsp_ch.mem_address;
                observed.mem_size      = rsp_ch.mem_size;
                observed.address_bytes = rsp_ch.address_bytes;
                observed.size_bytes    = rsp_ch.size_bytes;
                observed.data_offset   = rsp_ch.data_offset;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, observed.status);
                end
                else
                begin
                    predicted = pending_results.pop_front();
                    compare_field("status", predicted.status, observed.status);
                    compare_field("mem_address", predicted.mem_address, observed.mem_address);
                    compare_field("mem_size", predicted.mem_size, observed.mem_size);
                    compare_field("address_bytes", predicted.address_bytes,
                                  observed.address_bytes);
                    compare_field("size_bytes", predicted.size_bytes, observed.size_bytes);
                    compare_field("data_offset", predicted.data_offset, observed.data_offset);
                end
            end
            if (cycles >= LIMIT_CYCLES)
            begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int start_cnt;
        rst_n            = 1'b0;
        n_pushed         = 0;
        quiet            = 1'b0;
        long_hold_req    = 1'b0;
        repeat (3) @(posedge clk);
        #3 rst_n = 1'b1;

        // directed records
        add_record(8'h00, 32'h0, 32'h0, 0, 0);                  // format byte alone
        add_record(8'h44, 32'hFFFF_FFFF, 32'h0, 0, 0);          // widest header
        add_record(8'h44, 32'h0000_0000, 32'h0000_0003, 3, 0);
        add_record(8'h11, 32'hA5, 32'h2, 2, 0);
        add_record(8'h14, 32'h8000_0001, 32'h1, 1, 0);
        add_record(8'h05, 32'h0, 32'h0, 0, 0);                  // address nibble too big
        add_record(8'h50, 32'h0, 32'h0, 0, 0);                  // size nibble too big
        add_record(8'hFF, 32'h1234_5678, 32'h0, 2, 3);
        add_record(8'h44, 32'h0, 32'h0, 0, 1);                  // shorter than header
        add_record(8'h24, 32'h1122_3344, 32'h0, 0, 5);
        add_record(8'h12, 32'h00AB, 32'h3, 2, 0);               // payload one short
        add_record(8'h12, 32'h00AB, 32'h3, 4, 0);               // payload one long
        add_record(8'h40, 32'h0, 32'hFFFF_FFFF, 0, 0);          // huge size, no payload
        add_record(8'h30, 32'h0, 32'h00FF_FFFF, 3, 0);
        add_record(8'h01, 32'h7F, 32'h0, 0, 0);
        // pause the sender until everything is back
        wait_all_done();

        // hold the result side off while bytes keep coming
        long_hold_req = 1'b1;
        while (!long_hold_done)
            @(posedge clk);
        for (int i = 0; i < 30; i++)
            add_record(8'($urandom_range(0, 4) << 4 | $urandom_range(0, 4)), $urandom,
                       32'h0, 0, 0);
        wait_all_done();

        start_cnt = n_pushed;
        while (n_pushed - start_cnt < 320)
            add_random_record();
        while (tx_bytes.size() != 0)
            @(posedge clk);
        quiet = 1'b1;
        start_cnt = n_pushed;
        while (n_pushed - start_cnt < 60)
            add_random_record();

        wait_all_done();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/uwmrp_pkg.sv
rtl/uwmrp_req_if.sv
rtl/uwmrp_rsp_if.sv
rtl/uwmrp_accum.sv
rtl/uds_write_memory_request_parser.sv
tb/sv/tb_uds_write_memory_request_parser.sv
